>>> design/pts_pkg.sv
// Package for the priority task scheduler: operation and status codes,
// sequencer states and default sizes. No dependencies.
package pts_pkg;

    localparam int DEF_NUM_TASKS     = 16;
    localparam int DEF_PRIORITY_BITS = 8;
    localparam int CFG_INDEX_BITS    = 2;
    localparam int CFG_DATA_BITS     = 32;
    localparam int SLICE_BITS        = 17;
    localparam logic [SLICE_BITS-1:0] SLICE_MAX = '1;

    typedef enum logic [2:0] {
        OP_ADD      = 3'd0,
        OP_START    = 3'd1,
        OP_SCHEDULE = 3'd2,
        OP_BLOCK    = 3'd3,
        OP_WAKE     = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_NOTQ    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_QUANTUM = 2'd0,
        CFG_BONUS   = 2'd1,
        CFG_BASE    = 2'd2
    } cfg_index_t;

    localparam logic [1:0] CS_RUNNING = 2'd0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ENQ_WALK,
        S_DEQ_WALK,
        S_PICK,
        S_SLICE_MUL,
        S_SLICE_ADD,
        S_WAKE_SCAN,
        S_MASK_SCAN,
        S_DONE
    } state_t;

endpackage

>>> design/priority_task_scheduler.sv
// Top level of the priority task scheduler: sequencer, linked ready list,
// blocked table and enable mask scan. Depends on pts_pkg.
//
// Channel   Direction  Signals
// command   in         start, operation, task_id, priority_req, irq_number,
//                      current_state (busy is an output)
// result    out        done, status, next_task, slice_reload, irq_enable_mask,
//                      woken_count, ready_count
// config    in         cfg_we, cfg_index, cfg_data
//
// A command is a transfer when start is high and busy is low. After it the
// sequencer runs a decode step, a mask scan of one slot per cycle plus its exit
// step, and the result step. A list insert or removal also walks the list link
// by link, a start or schedule that picks a task adds the slice multiply and add
// steps, schedule also adds a pick step, and a wake adds a scan of every slot
// plus one insert walk per requeued slot. The result is on the output ports for
// one cycle with done high; the receiver cannot stall. Reset clears all list,
// flag and wait mask state at once.
module priority_task_scheduler
    import pts_pkg::*;
#(
    parameter int NUM_TASKS     = DEF_NUM_TASKS,
    parameter int PRIORITY_BITS = DEF_PRIORITY_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [2:0]                 operation,
    input  logic [3:0]                 task_id,
    input  logic [7:0]                 priority_req,
    input  logic [4:0]                 irq_number,
    input  logic [1:0]                 current_state,
    output logic                       done,
    output logic [1:0]                 status,
    output logic [3:0]                 next_task,
    output logic [SLICE_BITS-1:0]      slice_reload,
    output logic [31:0]                irq_enable_mask,
    output logic [4:0]                 woken_count,
    output logic [4:0]                 ready_count,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int IW = $clog2(NUM_TASKS);
    localparam int LW = $clog2(NUM_TASKS + 1);
    localparam int CW = $clog2(NUM_TASKS + 1);
    localparam logic [LW-1:0] NULL_LINK = LW'(NUM_TASKS);
    localparam int PW = PRIORITY_BITS;
    localparam int MW = PW + 8;

    state_t phase_reg, phase_next;

    logic [15:0] quantum_reg;
    logic [7:0]  bonus_reg;
    logic [31:0] base_reg;

    logic [LW-1:0] link_reg [NUM_TASKS];
    logic [LW-1:0] link_next_v [NUM_TASKS];
    logic [LW-1:0] head_reg, head_next;
    logic [NUM_TASKS-1:0] queued_reg, queued_next;
    logic [NUM_TASKS-1:0] blocked_reg, blocked_next;
    logic [31:0] wmask_reg [NUM_TASKS];
    logic [31:0] wmask_next [NUM_TASKS];
    logic [PW-1:0] prio_reg [NUM_TASKS];
    logic [CW-1:0] total_reg, total_next;
    logic [IW-1:0] running_reg, running_next;

    logic [2:0]  op_reg, op_next;
    logic [3:0]  id_reg, id_next;
    logic [PW-1:0] preq_reg, preq_next;
    logic [4:0]  irq_reg, irq_next;
    logic [1:0]  cs_reg, cs_next;

    logic [IW-1:0] tgt_reg, tgt_next;
    logic [LW-1:0] walk_reg, walk_next;
    logic [CW-1:0] steps_reg, steps_next;
    logic [IW:0]   scan_reg, scan_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [1:0]    stat_reg, stat_next;
    logic [MW-1:0] prod_reg, prod_next;
    logic [SLICE_BITS-1:0] slice_reg, slice_next;
    logic [31:0]   mask_reg, mask_next;
    logic [4:0]    woken_reg, woken_next;
    logic          prio_we;
    logic [IW-1:0] prio_wa;
    logic [PW-1:0] prio_wd;
    state_t        ret_reg, ret_next;

    logic id_ok;
    logic [IW-1:0] id_ix;
    logic [IW-1:0] walk_ix;
    logic [IW-1:0] scan_ix;
    logic [LW-1:0] walk_lnk;
    logic [PW+16:0] sum_w;

    assign id_ok   = 32'(id_reg) < NUM_TASKS;
    assign id_ix   = IW'(id_reg);
    assign walk_ix = walk_reg[IW-1:0];
    assign scan_ix = scan_reg[IW-1:0];
    assign walk_lnk = link_reg[walk_ix];
    assign sum_w   = (PW+17)'(quantum_reg) + (PW+17)'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= 16'd10;
            bonus_reg   <= 8'd2;
            base_reg    <= 32'd128;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_QUANTUM: quantum_reg <= cfg_data[15:0];
                CFG_BONUS:   bonus_reg   <= cfg_data[7:0];
                CFG_BASE:    base_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (prio_we)
        begin
            prio_reg[prio_wa] <= prio_wd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= S_IDLE;
            head_reg    <= NULL_LINK;
            queued_reg  <= '0;
            blocked_reg <= '0;
            total_reg   <= '0;
            running_reg <= '0;
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                link_reg[i]  <= NULL_LINK;
                wmask_reg[i] <= '0;
            end
        end
        else
        begin
            phase_reg   <= phase_next;
            head_reg    <= head_next;
            queued_reg  <= queued_next;
            blocked_reg <= blocked_next;
            total_reg   <= total_next;
            running_reg <= running_next;
            link_reg    <= link_next_v;
            wmask_reg   <= wmask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        id_reg        <= id_next;
        preq_reg      <= preq_next;
        irq_reg       <= irq_next;
        cs_reg        <= cs_next;
        tgt_reg       <= tgt_next;
        walk_reg      <= walk_next;
        steps_reg     <= steps_next;
        scan_reg      <= scan_next;
        cur_reg       <= cur_next;
        stat_reg      <= stat_next;
        prod_reg      <= prod_next;
        slice_reg     <= slice_next;
        mask_reg      <= mask_next;
        woken_reg     <= woken_next;
        ret_reg       <= ret_next;
    end

    always_comb
    begin
        phase_next     = phase_reg;
        head_next      = head_reg;
        queued_next    = queued_reg;
        blocked_next   = blocked_reg;
        total_next     = total_reg;
        running_next   = running_reg;
        link_next_v    = link_reg;
        wmask_next     = wmask_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        preq_next      = preq_reg;
        irq_next       = irq_reg;
        cs_next        = cs_reg;
        tgt_next       = tgt_reg;
        walk_next      = walk_reg;
        steps_next     = steps_reg;
        scan_next      = scan_reg;
        cur_next       = cur_reg;
        stat_next      = stat_reg;
        prod_next      = prod_reg;
        slice_next     = slice_reg;
        mask_next      = mask_reg;
        woken_next     = woken_reg;
        ret_next       = ret_reg;
        prio_we        = 1'b0;
        prio_wa        = id_ix;
        prio_wd        = preq_reg;

        unique case (phase_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = operation;
                    id_next    = task_id;
                    preq_next  = PW'(priority_req);
                    irq_next   = irq_number;
                    cs_next    = current_state;
                    stat_next  = ST_OK;
                    slice_next = '0;
                    woken_next = '0;
                    phase_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                phase_next = S_MASK_SCAN;
                scan_next  = '0;
                mask_next  = base_reg;
                case (op_reg)
                    OP_ADD:
                    begin
                        if (!id_ok)
                        begin
                            stat_next = ST_NOTQ;
                        end
                        else if (!queued_reg[id_ix])
                        begin
                            if (32'(total_reg) >= NUM_TASKS)
                            begin
                                stat_next = ST_FULL;
                            end
                            else
                            begin
                                prio_we    = 1'b1;
                                tgt_next   = id_ix;
                                walk_next  = head_reg;
                                steps_next = '0;
                                ret_next   = S_MASK_SCAN;
                                phase_next = S_ENQ_WALK;
                            end
                        end
                    end
                    OP_START:
                    begin
                        if (!id_ok || !queued_reg[id_ix])
                        begin
                            stat_next = ST_NOTQ;
                        end
                        else
                        begin
                            tgt_next     = id_ix;
                            running_next = id_ix;
                            walk_next    = head_reg;
                            steps_next   = '0;
                            phase_next   = S_DEQ_WALK;
                        end
                    end
                    OP_SCHEDULE:
                    begin
                        cur_next = running_reg;
                        if (cs_reg == CS_RUNNING && !queued_reg[running_reg] &&
                            32'(total_reg) < NUM_TASKS)
                        begin
                            tgt_next   = running_reg;
                            walk_next  = head_reg;
                            steps_next = '0;
                            ret_next   = S_PICK;
                            phase_next = S_ENQ_WALK;
                        end
                        else
                        begin
                            phase_next = S_PICK;
                        end
                    end
                    OP_BLOCK:
                    begin
                        if (!id_ok)
                        begin
                            stat_next = ST_NOTQ;
                        end
                        else
                        begin
                            blocked_next[id_ix] = 1'b1;
                            wmask_next[id_ix]   = wmask_reg[id_ix] | (32'd1 << irq_reg);
                        end
                    end
                    OP_WAKE:
                    begin
                        scan_next  = '0;
                        phase_next = S_WAKE_SCAN;
                    end
                    default: ;
                endcase
            end
            S_ENQ_WALK:
            begin
                if (walk_reg == NULL_LINK ||
                    (steps_reg == '0 && prio_reg[tgt_reg] > prio_reg[walk_ix]))
                begin
                    link_next_v[tgt_reg] = head_reg;
                    head_next            = LW'(tgt_reg);
                    queued_next[tgt_reg] = 1'b1;
                    total_next           = total_reg + 1'b1;
                    phase_next           = ret_reg;
                end
                else if (walk_lnk != NULL_LINK && 32'(steps_reg) < NUM_TASKS &&
                         prio_reg[walk_lnk[IW-1:0]] >= prio_reg[tgt_reg])
                begin
                    walk_next  = walk_lnk;
                    steps_next = steps_reg + 1'b1;
                end
                else
                begin
                    link_next_v[tgt_reg] = walk_lnk;
                    link_next_v[walk_ix] = LW'(tgt_reg);
                    queued_next[tgt_reg] = 1'b1;
                    total_next           = total_reg + 1'b1;
                    phase_next           = ret_reg;
                end
                if (phase_next == S_MASK_SCAN)
                begin
                    scan_next = '0;
                    mask_next = base_reg;
                end
            end
            S_DEQ_WALK:
            begin
                if (head_reg == LW'(tgt_reg) || walk_reg == NULL_LINK ||
                    32'(steps_reg) >= NUM_TASKS || walk_lnk == LW'(tgt_reg))
                begin
                    if (head_reg == LW'(tgt_reg))
                    begin
                        head_next = link_reg[tgt_reg];
                    end
                    else if (walk_reg != NULL_LINK && 32'(steps_reg) < NUM_TASKS)
                    begin
                        link_next_v[walk_ix] = link_reg[tgt_reg];
                    end
                    link_next_v[tgt_reg] = NULL_LINK;
                    queued_next[tgt_reg] = 1'b0;
                    if (total_reg != '0)
                    begin
                        total_next = total_reg - 1'b1;
                    end
                    prod_next  = MW'(prio_reg[tgt_reg] * bonus_reg);
                    phase_next = S_SLICE_MUL;
                end
                else
                begin
                    walk_next  = walk_lnk;
                    steps_next = steps_reg + 1'b1;
                end
            end
            S_PICK:
            begin
                if (total_reg == '0 || head_reg == NULL_LINK)
                begin
                    stat_next  = ST_EMPTY;
                    scan_next  = '0;
                    mask_next  = base_reg;
                    phase_next = S_MASK_SCAN;
                end
                else
                begin
                    if (head_reg == LW'(cur_reg) && link_reg[head_reg[IW-1:0]] != NULL_LINK)
                    begin
                        tgt_next = link_reg[head_reg[IW-1:0]][IW-1:0];
                    end
                    else
                    begin
                        tgt_next = head_reg[IW-1:0];
                    end
                    running_next = tgt_next;
                    walk_next    = head_reg;
                    steps_next   = '0;
                    phase_next   = S_DEQ_WALK;
                end
            end
            S_SLICE_MUL:
            begin
                phase_next = S_SLICE_ADD;
            end
            S_SLICE_ADD:
            begin
                if (sum_w > (PW+17)'(SLICE_MAX))
                begin
                    slice_next = SLICE_MAX;
                end
                else
                begin
                    slice_next = sum_w[SLICE_BITS-1:0];
                end
                scan_next  = '0;
                mask_next  = base_reg;
                phase_next = S_MASK_SCAN;
            end
            S_WAKE_SCAN:
            begin
                if (32'(scan_reg) >= NUM_TASKS)
                begin
                    scan_next  = '0;
                    mask_next  = base_reg;
                    phase_next = S_MASK_SCAN;
                end
                else if (blocked_reg[scan_ix] && wmask_reg[scan_ix][irq_reg])
                begin
                    wmask_next[scan_ix]   = '0;
                    blocked_next[scan_ix] = 1'b0;
                    woken_next            = woken_reg + 1'b1;
                    scan_next             = scan_reg + 1'b1;
                    if (!queued_reg[scan_ix] && 32'(total_reg) < NUM_TASKS)
                    begin
                        tgt_next   = scan_ix;
                        walk_next  = head_reg;
                        steps_next = '0;
                        ret_next   = S_WAKE_SCAN;
                        phase_next = S_ENQ_WALK;
                    end
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_MASK_SCAN:
            begin
                if (32'(scan_reg) >= NUM_TASKS)
                begin
                    phase_next = S_DONE;
                end
                else
                begin
                    if (blocked_reg[scan_ix])
                    begin
                        mask_next = mask_reg | wmask_reg[scan_ix];
                    end
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                phase_next = S_IDLE;
            end
            default:
            begin
                phase_next = S_IDLE;
            end
        endcase
    end

    assign busy            = phase_reg != S_IDLE;
    assign done            = phase_reg == S_DONE;
    assign status          = stat_reg;
    assign next_task       = 4'(running_reg);
    assign slice_reload    = slice_reg;
    assign irq_enable_mask = mask_reg;
    assign woken_count     = woken_reg;
    assign ready_count     = 5'(total_reg);

    // The ready count never exceeds the number of slots.
    assert property (@(posedge clk) disable iff (!rst_n) 32'(total_reg) <= NUM_TASKS)
        else $error("ready count exceeds slot count");

    // A result is always followed by a return to idle.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !busy)
        else $error("block stayed busy after a result");

    // A command is taken only from idle, and work starts on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy && !done)
        else $error("command transfer did not start work");

    // An empty list has no queued slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == NULL_LINK) |-> (queued_reg == '0))
        else $error("queued flags set on empty list");

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for priority_task_scheduler: drives commands, predicts
// each result with a behavioral scheduler model and compares every field.
// Depends on pts_pkg and the design files.
`timescale 1ns / 100ps

module tb;
    import pts_pkg::*;

    localparam int NT = 16;
    localparam logic [4:0] NIL = 5'd16;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]  st;
        logic [3:0]  nxt;
        logic [16:0] slice;
        logic [31:0] mask;
        logic [4:0]  woken;
        logic [4:0]  ready;
    } sched_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  operation = '0;
    logic [3:0]  task_id = '0;
    logic [7:0]  priority_req = '0;
    logic [4:0]  irq_number = '0;
    logic [1:0]  current_state = '0;
    logic        done;
    logic [1:0]  status;
    logic [3:0]  next_task;
    logic [16:0] slice_reload;
    logic [31:0] irq_enable_mask;
    logic [4:0]  woken_count;
    logic [4:0]  ready_count;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    priority_task_scheduler dut (.*);

    always #5 clk = ~clk;

    // Scheduler model state.
    logic [15:0] quantum;
    logic [7:0]  bonus;
    logic [31:0] base_mask;
    logic [4:0]  nxt_link [NT];
    logic [4:0]  head;
    logic        in_list [NT];
    logic [7:0]  prio [NT];
    logic        is_blocked [NT];
    logic [31:0] waits [NT];
    logic [4:0]  n_ready;
    logic [3:0]  current;
    logic        written [NT];

    sched_result_t pending_results[$];
    int errors = 0;
    int n_checked = 0;
    int n_sent = 0;
    int cycles = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic void model_reset();
        quantum = 16'd10;
        bonus = 8'd2;
        base_mask = 32'd128;
        head = NIL;
        n_ready = '0;
        current = '0;
        for (int i = 0; i < NT; i++)
        begin
            nxt_link[i] = NIL;
            in_list[i] = 1'b0;
            prio[i] = '0;
            is_blocked[i] = 1'b0;
            waits[i] = '0;
            written[i] = 1'b0;
        end
    endfunction

    function automatic void list_insert(input logic [3:0] id);
        logic [4:0] prev;
        if (head == NIL || prio[id] > prio[head[3:0]])
        begin
            nxt_link[id] = head;
            head = {1'b0, id};
        end
        else
        begin
            prev = head;
            while (nxt_link[prev[3:0]] != NIL && prio[nxt_link[prev[3:0]][3:0]] >= prio[id])
                prev = nxt_link[prev[3:0]];
            nxt_link[id] = nxt_link[prev[3:0]];
            nxt_link[prev[3:0]] = {1'b0, id};
        end
        in_list[id] = 1'b1;
        n_ready++;
    endfunction

    function automatic void list_remove(input logic [3:0] id);
        logic [4:0] walk;
        if (head == {1'b0, id})
            head = nxt_link[id];
        else
        begin
            walk = head;
            while (walk != NIL)
            begin
                if (nxt_link[walk[3:0]] == {1'b0, id})
                begin
                    nxt_link[walk[3:0]] = nxt_link[id];
                    break;
                end
                walk = nxt_link[walk[3:0]];
            end
        end
        nxt_link[id] = NIL;
        in_list[id] = 1'b0;
        if (n_ready > 0)
            n_ready--;
    endfunction

    function automatic logic [16:0] slice_for(input logic [3:0] id);
        logic [31:0] s;
        s = 32'(quantum) + 32'(prio[id]) * 32'(bonus);
        return (s > 32'h1FFFF) ? 17'h1FFFF : s[16:0];
    endfunction

    function automatic sched_result_t predict_command(input op_t op, input logic [3:0] id,
        input logic [7:0] p, input logic [4:0] irq, input logic [1:0] cs);
        sched_result_t r;
        logic [3:0] pick;
        logic [3:0] cur;
        r = '0;
        case (op)
            OP_ADD:
                if (!in_list[id])
                begin
                    if (n_ready >= NT)
                        r.st = ST_FULL;
                    else
                    begin
                        prio[id] = p;
                        written[id] = 1'b1;
                        list_insert(id);
                    end
                end
            OP_START:
                if (!in_list[id])
                    r.st = ST_NOTQ;
                else
                begin
                    list_remove(id);
                    current = id;
                    r.slice = slice_for(id);
                end
            OP_SCHEDULE:
            begin
                cur = current;
                if (cs == CS_RUNNING && !in_list[cur] && n_ready < NT)
                    list_insert(cur);
                if (n_ready == 0 || head == NIL)
                    r.st = ST_EMPTY;
                else
                begin
                    pick = head[3:0];
                    if (pick == cur && nxt_link[pick] != NIL)
                        pick = nxt_link[pick][3:0];
                    list_remove(pick);
                    current = pick;
                    r.slice = slice_for(pick);
                end
            end
            OP_BLOCK:
            begin
                is_blocked[id] = 1'b1;
                waits[id] |= 32'd1 << irq;
            end
            OP_WAKE:
                for (int i = 0; i < NT; i++)
                    if (is_blocked[i] && waits[i][irq])
                    begin
                        waits[i] = '0;
                        is_blocked[i] = 1'b0;
                        if (!in_list[i] && n_ready < NT)
                            list_insert(4'(i));
                        r.woken++;
                    end
            default: ;
        endcase
        r.nxt = current;
        r.mask = base_mask;
        for (int i = 0; i < NT; i++)
            if (is_blocked[i])
                r.mask |= waits[i];
        r.ready = n_ready;
        return r;
    endfunction

    task automatic send_command(input op_t op, input logic [3:0] id, input logic [7:0] p,
        input logic [4:0] irq, input logic [1:0] cs);
        int gap;
        gap = $urandom_range(0, 4);
        repeat (gap) @(posedge clk);
        operation <= op;
        task_id <= id;
        priority_req <= p;
        irq_number <= irq;
        current_state <= cs;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(predict_command(op, id, p, irq, cs));
        n_sent++;
        start <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [31:0] val);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_QUANTUM: quantum = val[15:0];
            CFG_BONUS:   bonus = val[7:0];
            default:     base_mask = val;
        endcase
    endtask

    // Schedule with a not-running state is always safe; running needs a written current.
    function automatic logic [1:0] safe_state(input logic [1:0] cs);
        if (cs == CS_RUNNING && !written[current] && !in_list[current])
            return 2'd1;
        return cs;
    endfunction

    task automatic test_directed();
        send_command(OP_SCHEDULE, 4'd0, 8'd0, 5'd0, 2'd1);
        send_command(OP_START, 4'd3, 8'd0, 5'd0, 2'd0);
        send_command(OP_ADD, 4'd0, 8'd0, 5'd0, 2'd0);
        send_command(OP_ADD, 4'd15, 8'd255, 5'd0, 2'd0);
        send_command(OP_ADD, 4'd5, 8'd255, 5'd0, 2'd0);
        send_command(OP_ADD, 4'd7, 8'd100, 5'd0, 2'd0);
        send_command(OP_ADD, 4'd5, 8'd1, 5'd0, 2'd0);
        send_command(OP_START, 4'd15, 8'd0, 5'd0, 2'd0);
        send_command(OP_SCHEDULE, 4'd0, 8'd0, 5'd0, 2'd0);
        send_command(OP_SCHEDULE, 4'd0, 8'd0, 5'd0, 2'd3);
        send_command(OP_BLOCK, 4'd7, 8'd0, 5'd31, 2'd0);
        send_command(OP_BLOCK, 4'd0, 8'd0, 5'd0, 2'd0);
        send_command(OP_BLOCK, 4'd5, 8'd0, 5'd31, 2'd0);
        send_command(OP_WAKE, 4'd0, 8'd0, 5'd31, 2'd0);
        send_command(OP_WAKE, 4'd0, 8'd0, 5'd0, 2'd0);
        send_command(OP_WAKE, 4'd0, 8'd0, 5'd9, 2'd0);
        send_command(OP_SCHEDULE, 4'd0, 8'd0, 5'd0, 2'd2);
        send_command(op_t'(3'd5), 4'd9, 8'd0, 5'd0, 2'd0);
        send_command(op_t'(3'd7), 4'd9, 8'd0, 5'd0, 2'd0);
    endtask

    task automatic test_full_queue();
        for (int i = 0; i < NT; i++)
            send_command(OP_ADD, 4'(i), 8'($urandom_range(0, 3)), 5'd0, 2'd0);
        send_command(OP_ADD, 4'd4, 8'd9, 5'd0, 2'd0);
        send_command(OP_SCHEDULE, 4'd0, 8'd0, 5'd0, 2'd0);
        wait_drained();
    endtask

    task automatic test_config_extremes();
        write_register(CFG_QUANTUM, 32'hFFFF);
        write_register(CFG_BONUS, 32'hFF);
        write_register(CFG_BASE, 32'hFFFFFFFF);
        send_command(OP_ADD, 4'd15, 8'd255, 5'd0, 2'd0);
        send_command(OP_START, 4'd15, 8'd0, 5'd0, 2'd0);
        write_register(CFG_QUANTUM, 32'd0);
        write_register(CFG_BONUS, 32'd0);
        write_register(CFG_BASE, 32'd0);
        send_command(OP_SCHEDULE, 4'd0, 8'd0, 5'd0, 2'd0);
    endtask

    task automatic test_random(input int count);
        int kind;
        logic [3:0] id;
        for (int n = 0; n < count; n++)
        begin
            if (n % 100 == 50)
            begin
                write_register(CFG_QUANTUM, $urandom);
                write_register(CFG_BONUS, $urandom);
                write_register(CFG_BASE, $urandom & $urandom);
            end
            kind = $urandom_range(0, 99);
            id = 4'($urandom);
            if (kind < 35)
                send_command(OP_ADD, id, 8'($urandom), 5'($urandom), 2'($urandom));
            else if (kind < 45)
                send_command(OP_START, id, 8'($urandom), 5'($urandom), 2'($urandom));
            else if (kind < 70)
                send_command(OP_SCHEDULE, id, 8'($urandom), 5'($urandom),
                    safe_state(2'($urandom)));
            else if (kind < 85)
                send_command(OP_BLOCK, id, 8'($urandom), 5'($urandom_range(0, 7)),
                    2'($urandom));
            else if (kind < 97)
                send_command(OP_WAKE, id, 8'($urandom), 5'($urandom_range(0, 7)),
                    2'($urandom));
            else
                send_command(op_t'(3'($urandom_range(5, 7))), id, 8'($urandom),
                    5'($urandom), 2'($urandom));
        end
    endtask

    always @(posedge clk)
    begin
        sched_result_t e;
        if (done)
        begin
            if (pending_results.size() == 0)
                report("unexpected result", 32'd1, 32'd0);
            else
            begin
                e = pending_results.pop_front();
                n_checked++;
                if (status !== e.st)
                    report("status", 32'(status), 32'(e.st));
                if (next_task !== e.nxt)
                    report("next_task", 32'(next_task), 32'(e.nxt));
                if (slice_reload !== e.slice)
                    report("slice_reload", 32'(slice_reload), 32'(e.slice));
                if (irq_enable_mask !== e.mask)
                    report("irq_enable_mask", irq_enable_mask, e.mask);
                if (woken_count !== e.woken)
                    report("woken_count", 32'(woken_count), 32'(e.woken));
                if (ready_count !== e.ready)
                    report("ready_count", 32'(ready_count), 32'(e.ready));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        model_reset();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_queue();
        test_config_extremes();
        test_random(500);
        wait_drained();
        if (pending_results.size() != 0)
            errors++;
        $display("Sent %0d commands and checked %0d results, covering all operations,",
            n_sent, n_checked);
        $display("a full ready list, empty schedules and register extremes.");
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
